// ----- design/pacr_pkg.sv -----
// shared types and constants of the phase adaptive replacement block
package pacr_pkg;

   localparam int SETS          = 2048;
   localparam int SET_BITS      = 11;
   localparam int WAYS          = 16;
   localparam int WAY_BITS      = 4;
   localparam int ADDR_BITS     = 48;
   localparam int DELTA_BITS    = ADDR_BITS + 1;
   localparam int REUSE_BITS    = 16;
   localparam int STRIDE_WINDOW = 8;
   localparam int RUN_BITS      = 3;
   localparam int FILL_BITS     = 4;
   localparam int HIT_WINDOW    = 16;
   localparam int HCNT_BITS     = 5;
   localparam int THR_BITS      = 5;
   localparam int DIST_BITS     = 13;
   localparam int KEY_BITS      = REUSE_BITS + 1;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [REUSE_BITS-1:0] REUSE_MAX = {REUSE_BITS{1'b1}};
   localparam logic [THR_BITS-1:0]   THR_RESET = THR_BITS'(10);
   localparam logic [DIST_BITS-1:0]  DIST_RESET = DIST_BITS'(64);

   localparam logic [CSR_IDX_BITS-1:0] CSR_PHASE_THRESHOLD  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPATIAL_DISTANCE = CSR_IDX_BITS'(1);

   localparam logic KIND_QUERY  = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   typedef struct packed {
      logic                  is_query;
      logic [SET_BITS-1:0]   set_index;
      logic [WAY_BITS-1:0]   way;
      logic [ADDR_BITS-1:0]  address;
      logic                  hit;
   } req_type;

   typedef struct packed {
      logic [WAY_BITS-1:0] victim_way;
      logic                regular;
      logic                took_invalid;
   } rsp_type;

   typedef struct packed {
      logic                 push;
      rsp_type              data;
   } rsp_push_type;

   typedef struct packed {
      logic [THR_BITS-1:0]  phase_threshold;
      logic [DIST_BITS-1:0] spatial_distance;
   } cfg_type;

   typedef struct packed {
      logic [WAYS-1:0]                 valid;
      logic [WAYS-1:0][WAY_BITS-1:0]   rank;
      logic [WAYS-1:0][REUSE_BITS-1:0] reuse;
      logic [WAYS-1:0]                 spatial;
      logic [ADDR_BITS-1:0]            last_address;
      logic [DELTA_BITS-1:0]           last_delta;
      logic [RUN_BITS-1:0]             delta_run;
      logic [FILL_BITS-1:0]            fill;
      logic [HIT_WINDOW-1:0]           hits;
   } row_type;

   function automatic row_type reset_row();
      row_type r;
      r = '0;
      for (int w = 0; w < WAYS; w++) begin
         r.rank[w] = WAY_BITS'(w);
      end
      return r;
   endfunction

endpackage

// ----- design/phase_adaptive_cache_replacement.sv -----
// top level of the phase adaptive cache replacement policy
// Replacement policy for a 2048-set, 16-way cache. A request with kind 0 asks
// for a victim in a set and yields one response; kind 1 reports an access and
// yields none. The back end works through each request (read of the set
// row from its single-port memory, evaluation, then response or write-back),
// one request at a time; a query right behind another query waits while the
// first response moves from the output register into the response queue, and
// a query also waits while that queue is full. A two-entry request queue and
// a two-entry response queue decouple the ports.
// After reset the set memory is swept to its reset state, one set per cycle;
// full stays high until the sweep is done. Configuration writes are always
// taken.
module phase_adaptive_cache_replacement
   import pacr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    push,
   output logic                    full,
   input  logic                    req_kind,
   input  logic [SET_BITS-1:0]     req_set_index,
   input  logic [WAY_BITS-1:0]     req_way,
   input  logic [ADDR_BITS-1:0]    req_address,
   input  logic                    req_hit,
   // response channel
   output logic                    empty,
   input  logic                    pop,
   output logic [WAY_BITS-1:0]     rsp_victim_way,
   output logic                    rsp_regular_phase,
   output logic                    rsp_took_invalid,
   // configuration writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [DIST_BITS-1:0]    csr_data
);

   cfg_type      cfg_ff, cfg_in;
   logic         fq_full, head_valid, back_pop, clearing, rq_full;
   req_type      head;
   rsp_push_type rsp_push;
   rsp_type      rsp_head;

   // config registers, writes always accepted
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PHASE_THRESHOLD:  cfg_in.phase_threshold  = csr_data[THR_BITS-1:0];
            CSR_SPATIAL_DISTANCE: cfg_in.spatial_distance = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_threshold  <= THR_RESET;
         cfg_ff.spatial_distance <= DIST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // no requests taken while the set memory is being swept
   assign full = fq_full || clearing;

   pacr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push && !clearing),
      .kind       (req_kind),
      .set_index  (req_set_index),
      .way        (req_way),
      .address    (req_address),
      .hit        (req_hit),
      .full       (fq_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (back_pop)
   );

   pacr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (back_pop),
      .rsp_full   (rq_full),
      .rsp_out    (rsp_push),
      .clearing   (clearing)
   );

   pacr_rsp_q u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .in_push (rsp_push),
      .full    (rq_full),
      .empty   (empty),
      .head    (rsp_head),
      .pop     (pop)
   );

   assign rsp_victim_way    = rsp_head.victim_way;
   assign rsp_regular_phase = rsp_head.regular;
   assign rsp_took_invalid  = rsp_head.took_invalid;

   // request side closed during the sweep
   a_full_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> full)
      else $error("request accepted during memory sweep");

   // back end only finishes a query when the response queue has room
   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push.push |-> !rq_full)
      else $error("response pushed into full queue");

   // an invalid-way pick never reports a phase
   a_invalid_no_phase: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_took_invalid && rsp_regular_phase))
      else $error("invalid way reported with regular phase");

endmodule

// ----- design/pacr_front.sv -----
// front end: request queue that classifies incoming requests
module pacr_front
   import pacr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic                 kind,
   input  logic [SET_BITS-1:0]  set_index,
   input  logic [WAY_BITS-1:0]  way,
   input  logic [ADDR_BITS-1:0] address,
   input  logic                 hit,
   output logic                 full,
   output logic                 head_valid,
   output req_type              head,
   input  logic                 pop
);

   req_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;
   req_type    item;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = ent_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      item.is_query  = (kind == KIND_QUERY);
      item.set_index = set_index;
      item.way       = way;
      item.address   = address;
      item.hit       = hit;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/pacr_rsp_q.sv -----
// result queue between the back end and the response port
module pacr_rsp_q
   import pacr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type in_push,
   output logic         full,
   output logic         empty,
   output rsp_type      head,
   input  logic         pop
);

   rsp_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = ent_ff[rd_ptr_ff];
   assign do_push = in_push.push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= in_push.data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/pacr_back.sv -----
// back end: set row memory, victim choice and state update sequencer
module pacr_back
   import pacr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         head_valid,
   input  req_type      head,
   output logic         pop,
   input  logic         rsp_full,
   output rsp_push_type rsp_out,
   output logic         clearing
);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EVAL, ST_FINISH} state_type;

   row_type mem [SETS];
   row_type rd_row_ff;

   state_type            state_ff, state_in;
   logic [SET_BITS-1:0]  clr_ff, clr_in;
   req_type              cmd_ff, cmd_in;
   row_type              wr_row_ff, wr_row_in;
   logic                 inv_ff, inv_in;
   logic [WAY_BITS-1:0]  inv_way_ff, inv_way_in;
   logic                 regular_ff, regular_in;
   logic [KEY_BITS-1:0]  key_reg_ff [WAYS];
   logic [KEY_BITS-1:0]  key_reg_in [WAYS];
   logic [KEY_BITS-1:0]  key_old_ff [WAYS];
   logic [KEY_BITS-1:0]  key_old_in [WAYS];
   rsp_push_type         rsp_ff, rsp_in;

   logic                 take;
   logic                 any_ns, any_zero, stride;
   logic [HCNT_BITS-1:0] hcnt;
   logic [FILL_BITS-1:0] win_len;
   logic [DELTA_BITS-1:0] delta;
   logic [ADDR_BITS-1:0] gap;
   logic                 spatial;
   logic [WAYS-1:0]      win;
   logic [KEY_BITS-1:0]  key [WAYS];
   logic [WAY_BITS-1:0]  victim;
   row_type              r;

   assign clearing = (state_ff == ST_CLEAR);
   // a response still in the output register counts against the queue room
   assign take     = (state_ff == ST_IDLE) && head_valid
                     && !(head.is_query && (rsp_full || rsp_ff.push));
   assign pop      = take;
   assign rsp_out  = rsp_ff;

   // memory: one set row per address, registered read
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         mem[clr_ff] <= reset_row();
      end else if (state_ff == ST_FINISH && !cmd_ff.is_query) begin
         mem[cmd_ff.set_index] <= wr_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rd_row_ff <= mem[head.set_index];
      end
   end

   // evaluation of the read row
   always_comb begin
      r = rd_row_ff;
      inv_in     = 1'b0;
      inv_way_in = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!r.valid[w]) begin
            inv_in     = 1'b1;
            inv_way_in = WAY_BITS'(w);
         end
      end
      hcnt = '0;
      for (int i = 0; i < HIT_WINDOW; i++) begin
         hcnt = hcnt + HCNT_BITS'(r.hits[i]);
      end
      win_len = (r.fill < FILL_BITS'(STRIDE_WINDOW)) ? r.fill : FILL_BITS'(STRIDE_WINDOW);
      stride  = (r.fill >= FILL_BITS'(3))
                && ({1'b0, r.delta_run} >= (win_len - FILL_BITS'(1)))
                && (r.last_delta[31:0] != 32'd0);
      regular_in = stride || (hcnt >= cfg.phase_threshold);
      any_ns   = 1'b0;
      any_zero = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         any_ns   = any_ns | !r.spatial[w];
         any_zero = any_zero | (r.reuse[w] == '0);
      end
      for (int w = 0; w < WAYS; w++) begin
         key_reg_in[w] = {any_ns & r.spatial[w], r.reuse[w]};
         key_old_in[w] = KEY_BITS'({any_zero & (r.reuse[w] != '0), ~r.rank[w]});
      end

      // update of the row
      wr_row_in = r;
      for (int i = 0; i < WAYS; i++) begin
         if (r.rank[i] < r.rank[cmd_ff.way]) begin
            wr_row_in.rank[i] = r.rank[i] + WAY_BITS'(1);
         end
      end
      wr_row_in.rank[cmd_ff.way] = '0;
      if (cmd_ff.hit) begin
         if (r.reuse[cmd_ff.way] != REUSE_MAX) begin
            wr_row_in.reuse[cmd_ff.way] = r.reuse[cmd_ff.way] + REUSE_BITS'(1);
         end
      end else begin
         wr_row_in.reuse[cmd_ff.way] = '0;
      end
      delta   = {1'b0, cmd_ff.address} - {1'b0, r.last_address};
      gap     = delta[DELTA_BITS-1] ? (r.last_address - cmd_ff.address) : delta[ADDR_BITS-1:0];
      spatial = 1'b0;
      if (r.fill != '0) begin
         spatial = (gap <= ADDR_BITS'(cfg.spatial_distance));
         if (r.fill == FILL_BITS'(1) || delta != r.last_delta) begin
            wr_row_in.delta_run = RUN_BITS'(1);
         end else if (r.delta_run < RUN_BITS'(STRIDE_WINDOW - 1)) begin
            wr_row_in.delta_run = r.delta_run + RUN_BITS'(1);
         end
         wr_row_in.last_delta = delta;
      end
      wr_row_in.spatial[cmd_ff.way] = spatial;
      wr_row_in.last_address = cmd_ff.address;
      if (r.fill < FILL_BITS'(STRIDE_WINDOW)) begin
         wr_row_in.fill = r.fill + FILL_BITS'(1);
      end
      wr_row_in.hits = {r.hits[HIT_WINDOW-2:0], cmd_ff.hit};
      wr_row_in.valid[cmd_ff.way] = 1'b1;
   end

   // victim pick: smallest key, lowest way on ties
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         key[w] = regular_ff ? key_reg_ff[w] : key_old_ff[w];
      end
      for (int w = 0; w < WAYS; w++) begin
         win[w] = 1'b1;
         for (int v = 0; v < WAYS; v++) begin
            if (v < w && key[w] >= key[v]) begin
               win[w] = 1'b0;
            end
            if (v > w && key[w] > key[v]) begin
               win[w] = 1'b0;
            end
         end
      end
      victim = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (win[w]) begin
            victim = victim | WAY_BITS'(w);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      cmd_in   = cmd_ff;
      rsp_in   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SET_BITS'(1);
            if (clr_ff == SET_BITS'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               cmd_in   = head;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (cmd_ff.is_query) begin
               rsp_in.push = 1'b1;
               if (inv_ff) begin
                  rsp_in.data.victim_way   = inv_way_ff;
                  rsp_in.data.regular      = 1'b0;
                  rsp_in.data.took_invalid = 1'b1;
               end else begin
                  rsp_in.data.victim_way   = victim;
                  rsp_in.data.regular      = regular_ff;
                  rsp_in.data.took_invalid = 1'b0;
               end
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      wr_row_ff  <= wr_row_in;
      inv_ff     <= inv_in;
      inv_way_ff <= inv_way_in;
      regular_ff <= regular_in;
      key_reg_ff <= key_reg_in;
      key_old_ff <= key_old_in;
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rsp_ff   <= rsp_in;
      end
   end

endmodule

// ----- tb/sv/pacr_checker.sv -----
// checker for the phase adaptive replacement block: predicts victims and compares responses
`timescale 1ns / 1ps
module pacr_checker
   import pacr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic                    full,
   input  logic                    req_kind,
   input  logic [SET_BITS-1:0]     req_set_index,
   input  logic [WAY_BITS-1:0]     req_way,
   input  logic [ADDR_BITS-1:0]    req_address,
   input  logic                    req_hit,
   input  logic                    empty,
   input  logic                    pop,
   input  logic [WAY_BITS-1:0]     rsp_victim_way,
   input  logic                    rsp_regular_phase,
   input  logic                    rsp_took_invalid,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [DIST_BITS-1:0]    csr_data,
   output int                      failures,
   output int                      pending
);

   logic                  line_ok    [SETS][WAYS];
   logic [WAY_BITS-1:0]   age        [SETS][WAYS];
   logic [REUSE_BITS-1:0] reuse      [SETS][WAYS];
   logic                  near       [SETS][WAYS];
   logic [ADDR_BITS-1:0]  prev_addr  [SETS];
   logic [DELTA_BITS-1:0] prev_delta [SETS];
   logic [RUN_BITS-1:0]   run_len    [SETS];
   logic [FILL_BITS-1:0]  seen       [SETS];
   logic [HIT_WINDOW-1:0] hit_bits   [SETS];
   logic [THR_BITS-1:0]   threshold;
   logic [DIST_BITS-1:0]  near_limit;
   rsp_type               victims_due[$];

   function automatic logic set_regular(int s);
      int span;
      logic stride;
      stride = 1'b0;
      if (seen[s] >= 3) begin
         span = ((seen[s] < STRIDE_WINDOW) ? seen[s] : STRIDE_WINDOW) - 1;
         stride = (run_len[s] >= span) && (prev_delta[s][31:0] != 32'd0);
      end
      return stride || ($countones(hit_bits[s]) >= threshold);
   endfunction

   function automatic rsp_type choose_victim(int s);
      rsp_type r;
      int pick;
      int best;
      r = '0;
      pick = -1;
      best = 0;
      for (int w = 0; w < WAYS; w++) begin
         if (!line_ok[s][w] && pick < 0) pick = w;
      end
      if (pick >= 0) begin
         r.victim_way = WAY_BITS'(pick);
         r.took_invalid = 1'b1;
         return r;
      end
      r.regular = set_regular(s);
      if (r.regular) begin
         // lowest reuse among non-spatial lines, else among all
         for (int w = 0; w < WAYS; w++) begin
            if (!near[s][w] && (pick < 0 || reuse[s][w] < best)) begin
               best = reuse[s][w];
               pick = w;
            end
         end
         if (pick < 0) begin
            for (int w = 0; w < WAYS; w++) begin
               if (pick < 0 || reuse[s][w] < best) begin
                  best = reuse[s][w];
                  pick = w;
               end
            end
         end
      end else begin
         // oldest dead line, else oldest line
         best = -1;
         for (int w = 0; w < WAYS; w++) begin
            if (reuse[s][w] == '0 && int'(age[s][w]) > best) begin
               best = age[s][w];
               pick = w;
            end
         end
         if (pick < 0) begin
            for (int w = 0; w < WAYS; w++) begin
               if (int'(age[s][w]) > best) begin
                  best = age[s][w];
                  pick = w;
               end
            end
         end
      end
      if (pick < 0) pick = 0;
      r.victim_way = WAY_BITS'(pick);
      return r;
   endfunction

   task automatic record_access(int s, int w, logic [ADDR_BITS-1:0] a, logic h);
      logic [WAY_BITS-1:0]   old;
      logic [ADDR_BITS-1:0]  gap;
      logic [DELTA_BITS-1:0] delta;
      logic                  sp;
      old = age[s][w];
      for (int i = 0; i < WAYS; i++) begin
         if (age[s][i] < old) age[s][i] = age[s][i] + 1'b1;
      end
      age[s][w] = '0;
      if (h) begin
         if (reuse[s][w] != REUSE_MAX) reuse[s][w] = reuse[s][w] + 1'b1;
      end else begin
         reuse[s][w] = '0;
      end
      sp = 1'b0;
      if (seen[s] > 0) begin
         gap = (a >= prev_addr[s]) ? a - prev_addr[s] : prev_addr[s] - a;
         sp = gap <= ADDR_BITS'(near_limit);
         delta = {1'b0, a} - {1'b0, prev_addr[s]};
         if (seen[s] == 1 || delta != prev_delta[s]) run_len[s] = RUN_BITS'(1);
         else if (run_len[s] < STRIDE_WINDOW - 1) run_len[s] = run_len[s] + 1'b1;
         prev_delta[s] = delta;
      end
      near[s][w] = sp;
      prev_addr[s] = a;
      if (seen[s] < STRIDE_WINDOW) seen[s] = seen[s] + 1'b1;
      hit_bits[s] = {hit_bits[s][HIT_WINDOW-2:0], h};
      line_ok[s][w] = 1'b1;
   endtask

   assign pending = victims_due.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
               line_ok[s][w] = 1'b0;
               age[s][w] = WAY_BITS'(w);
               reuse[s][w] = '0;
               near[s][w] = 1'b0;
            end
            prev_addr[s] = '0;
            prev_delta[s] = '0;
            run_len[s] = '0;
            seen[s] = '0;
            hit_bits[s] = '0;
         end
         threshold = THR_RESET;
         near_limit = DIST_RESET;
         victims_due.delete();
         failures = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PHASE_THRESHOLD) threshold = csr_data[THR_BITS-1:0];
            else if (csr_index == CSR_SPATIAL_DISTANCE) near_limit = csr_data;
         end
         if (push && !full) begin
            if (req_kind == KIND_QUERY)
               victims_due.insert(victims_due.size(), choose_victim(req_set_index));
            else record_access(req_set_index, req_way, req_address, req_hit);
         end
         if (pop && !empty) begin
            if (victims_due.size() == 0) begin
               $display("%0t: unexpected response way %0d", $time, rsp_victim_way);
               failures++;
            end else begin
               want = victims_due.pop_front();
               if (want.victim_way !== rsp_victim_way) begin
                  $display("%0t: victim_way expected %0d actual %0d", $time,
                           want.victim_way, rsp_victim_way);
                  failures++;
               end
               if (want.regular !== rsp_regular_phase) begin
                  $display("%0t: regular expected %0d actual %0d", $time,
                           want.regular, rsp_regular_phase);
                  failures++;
               end
               if (want.took_invalid !== rsp_took_invalid) begin
                  $display("%0t: took_invalid expected %0d actual %0d", $time,
                           want.took_invalid, rsp_took_invalid);
                  failures++;
               end
            end
         end
      end
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench top: stimulus, idling and verdict for the phase adaptive replacement block
`timescale 1ns / 1ps
module tb_top;
   import pacr_pkg::*;

   logic                    clock;
   logic                    reset;
   logic                    push;
   logic                    full;
   logic                    req_kind;
   logic [SET_BITS-1:0]     req_set_index;
   logic [WAY_BITS-1:0]     req_way;
   logic [ADDR_BITS-1:0]    req_address;
   logic                    req_hit;
   logic                    empty;
   logic                    pop;
   logic [WAY_BITS-1:0]     rsp_victim_way;
   logic                    rsp_regular_phase;
   logic                    rsp_took_invalid;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [DIST_BITS-1:0]    csr_data;
   int                      failures;
   int                      pending;

   // idling odds in percent, and a long receiver hold-off for back pressure
   int                      send_idle;
   int                      take_idle;
   int                      hold_off;
   int                      quiet_cycles;

   // per hot set: running address and stride of a streaming pattern
   logic [SET_BITS-1:0]     hot_set [8];
   logic [ADDR_BITS-1:0]    stream_addr [8];
   logic [ADDR_BITS-1:0]    stream_step [8];

   phase_adaptive_cache_replacement dut (.*);

   pacr_checker u_check (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog: ends the run if nothing moves for too long (covers the reset sweep)
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 12000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: random pop, with an occasional long hold-off
   initial begin
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            hold_off = hold_off - 1;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= take_idle);
         end
      end
   end

   task automatic send(logic k, logic [SET_BITS-1:0] s, logic [WAY_BITS-1:0] w,
                       logic [ADDR_BITS-1:0] a, logic h);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_kind <= k;
      req_set_index <= s;
      req_way <= w;
      req_address <= a;
      req_hit <= h;
      do @(posedge clock); while (full);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [DIST_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering, let every response come back, then let trailing updates retire
   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [ADDR_BITS-1:0] any_addr();
      return ADDR_BITS'({$urandom, $urandom});
   endfunction

   task automatic random_traffic(int count);
      int n;
      int r;
      for (int i = 0; i < count; i++) begin
         n = $urandom_range(7);
         r = $urandom_range(99);
         if (r < 50) begin
            // access on a hot set: mostly streaming, sometimes a jump
            if ($urandom_range(19) == 0) begin
               stream_addr[n] = any_addr();
               case ($urandom_range(3))
                  0: stream_step[n] = ADDR_BITS'(64);
                  1: stream_step[n] = -ADDR_BITS'($urandom_range(8192));
                  2: stream_step[n] = ADDR_BITS'(64'h1_0000_0000);
                  default: stream_step[n] = any_addr();
               endcase
            end
            if ($urandom_range(4) == 0) stream_addr[n] = any_addr();
            else stream_addr[n] = stream_addr[n] + stream_step[n];
            send(KIND_UPDATE, hot_set[n], WAY_BITS'($urandom_range(WAYS - 1)),
                 stream_addr[n], $urandom_range(99) < 60);
         end else if (r < 85) begin
            send(KIND_QUERY, hot_set[n], WAY_BITS'($urandom), any_addr(), 1'($urandom));
         end else if (r < 93) begin
            send(KIND_QUERY, SET_BITS'($urandom), WAY_BITS'($urandom), any_addr(),
                 1'($urandom));
         end else begin
            send(KIND_UPDATE, SET_BITS'($urandom), WAY_BITS'($urandom), any_addr(),
                 1'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_kind = KIND_QUERY;
      req_set_index = '0;
      req_way = '0;
      req_address = '0;
      req_hit = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_PHASE_THRESHOLD;
      csr_data = '0;
      send_idle = 6;
      take_idle = 88;
      hold_off = 0;
      hot_set[0] = '0;
      hot_set[1] = '1;
      for (int i = 2; i < 8; i++) hot_set[i] = SET_BITS'(i * 37);
      for (int i = 0; i < 8; i++) begin
         stream_addr[i] = any_addr();
         stream_step[i] = ADDR_BITS'(64);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // phase one: threshold zero, widest spatial distance
      write_csr(CSR_PHASE_THRESHOLD, DIST_BITS'(0));
      write_csr(CSR_SPATIAL_DISTANCE, DIST_BITS'(4096));

      // directed: empty set, top set and top address, extreme way
      send(KIND_QUERY, '0, '0, '0, 1'b0);
      send(KIND_UPDATE, '1, '1, '1, 1'b1);
      send(KIND_QUERY, '1, '0, '0, 1'b0);
      // first access of a set, then a full set with a steady 64-byte stride
      for (int w = 0; w < WAYS; w++)
         send(KIND_UPDATE, SET_BITS'(5), WAY_BITS'(w), ADDR_BITS'(w * 64), 1'b0);
      send(KIND_QUERY, SET_BITS'(5), '0, '0, 1'b0);
      send(KIND_UPDATE, SET_BITS'(5), WAY_BITS'(3), ADDR_BITS'(2000), 1'b1);
      send(KIND_QUERY, SET_BITS'(5), '0, '0, 1'b0);

      // back pressure: receiver holds off while requests keep coming
      hold_off = 300;
      random_traffic(400);
      drain();

      // phase two: threshold sixteen, zero spatial distance, roles swapped
      write_csr(CSR_PHASE_THRESHOLD, DIST_BITS'(16));
      write_csr(CSR_SPATIAL_DISTANCE, DIST_BITS'(0));
      send_idle = 88;
      take_idle = 6;
      random_traffic(400);
      drain();

      // phase three: mid settings, nobody idles
      write_csr(CSR_PHASE_THRESHOLD, DIST_BITS'($urandom_range(1, 15)));
      write_csr(CSR_SPATIAL_DISTANCE, DIST_BITS'($urandom_range(4095)));
      send_idle = 0;
      take_idle = 0;
      random_traffic(430);
      drain();

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
